>>> rtl/obbl_pkg.sv
// Package for the order book best-levels block: widths, codes and word types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package obbl_pkg;
  localparam int CAPACITY      = 64;
  localparam int SLOT_W        = $clog2(CAPACITY);
  localparam int BEST_PER_SIDE = 5;
  localparam int PICK_W        = $clog2(BEST_PER_SIDE + 1);

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_EDIT = 3'd1;
  localparam logic [2:0] OP_DEL  = 3'd2;
  localparam logic [2:0] OP_GET  = 3'd3;
  localparam logic [2:0] OP_BEST = 3'd4;
  localparam logic [2:0] OP_CLR  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NF    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] order_id;
    logic [31:0] price;
    logic [63:0] amount;
    logic        side;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_id;
    logic [31:0] result_price;
    logic [63:0] result_amount;
    logic        result_side;
    logic        last;
  } out_word_t;

  // one stored order
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [63:0] amount;
    logic        side;
    logic [31:0] stamp;
  } slot_t;
endpackage
`default_nettype wire

>>> rtl/obbl_in_if.sv
// Valid/ready channel carrying input words.
// Depends on obbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface obbl_in_if;
  import obbl_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/obbl_out_if.sv
// Valid/ready channel carrying result words.
// Depends on obbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface obbl_out_if;
  import obbl_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/obbl_slot_ram.sv
// Slot memory of the order table: one write port, one registered read port.
// Depends on obbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obbl_slot_ram (
  input  wire                          clk,
  input  wire                          we,
  input  wire [obbl_pkg::SLOT_W-1:0]   waddr,
  input  wire obbl_pkg::slot_t         wdata,
  input  wire [obbl_pkg::SLOT_W-1:0]   raddr,
  output obbl_pkg::slot_t              rdata
);
  import obbl_pkg::*;
  slot_t mem [CAPACITY];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/order_book_best_levels_core.sv
// Top level of the order book best-levels block.
// Depends on obbl_pkg, obbl_in_if, obbl_out_if and obbl_slot_ram.
`timescale 1ns / 1ps
`default_nettype none
// Order table of CAPACITY slots held in a single-port-read RAM, with valid
// and "shown" flags in flops. Items are taken one at a time. Add and clear
// act at once: the word sits in the output register the next cycle and the
// next item is taken once it is gone. Unused codes are taken and dropped
// with no result word. Edit, delete and get sweep the table once, one slot
// per cycle through the registered read port, then act on the result and
// hand off the word. Best runs one sweep per reported order plus one empty
// sweep on a side that runs short, at most 2*BEST_PER_SIDE sweeps. Each best
// word is held back until the next sweep, or a full buy side, shows whether
// another follows, so last can be set on the final one. Results leave
// through an output register; no further item or sweep starts until that
// word is taken.
module order_book_best_levels_core (
  input wire         clk,
  input wire         rst,
  obbl_in_if.sink    in_ch,
  obbl_out_if.source out_ch
);
  import obbl_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;  // sweep RAM
  localparam logic [2:0] S_DONE = 3'd2;  // act on scan result
  localparam logic [2:0] S_WAIT = 3'd3;  // result word pending

  logic [2:0]          state;
  in_word_t            cmd;
  logic [CAPACITY-1:0] valid_bits, shown;
  logic [31:0]         id_counter, stamp_counter;
  logic [SLOT_W:0]     scan_idx;     // address issued
  logic                rd_pend;      // read data valid this cycle
  logic [SLOT_W-1:0]   rd_slot;
  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  slot_t               hit_data;
  logic                pass_sell;    // current best pass side
  logic [PICK_W-1:0]   picks;        // reported on this side
  logic                pend_v;       // best word held back
  slot_t               pend;
  logic                best_more;    // another scan follows this word

  logic                we;
  logic [SLOT_W-1:0]   waddr;
  slot_t               wdata, rdata;

  obbl_slot_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(scan_idx[SLOT_W-1:0]), .rdata(rdata)
  );

  out_word_t ow;
  logic      ov;
  assign out_ch.valid = ov;
  assign out_ch.data  = ow;
  assign in_ch.ready  = (state == S_IDLE) && !ov;

  // lowest free slot, priority encoder
  logic              free_any;
  logic [SLOT_W-1:0] free_slot;
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // RAM writes: accepted add with a free slot and id, or edit that found its order
  logic add_go, edit_go;
  assign add_go  = (state == S_IDLE) && in_ch.valid && !ov &&
                   (in_ch.data.operation == OP_ADD) && free_any &&
                   (id_counter != 32'hFFFF_FFFF);
  assign edit_go = (state == S_DONE) && (cmd.operation == OP_EDIT) && hit;

  // candidate test for the slot whose data just returned
  logic cand, better;
  always_comb begin
    cand   = 1'b0;
    better = 1'b0;
    if (cmd.operation == OP_BEST) begin
      cand = valid_bits[rd_slot] && !shown[rd_slot] && (rdata.side == pass_sell);
      if (pass_sell)
        better = (rdata.price < hit_data.price) ||
                 ((rdata.price == hit_data.price) && (rdata.stamp < hit_data.stamp));
      else
        better = (rdata.price > hit_data.price) ||
                 ((rdata.price == hit_data.price) && (rdata.stamp > hit_data.stamp));
    end else begin
      cand   = valid_bits[rd_slot] && (rdata.id == cmd.order_id);
      better = 1'b0;  // first match wins
    end
  end

  function automatic out_word_t blank(input logic [1:0] st, input logic [31:0] id);
    out_word_t w;
    w = '0;
    w.status    = st;
    w.result_id = id;
    w.last      = 1'b1;
    return w;
  endfunction

  function automatic out_word_t slot_word(input slot_t d, input logic lst);
    out_word_t w;
    w.status        = ST_OK;
    w.result_id     = d.id;
    w.result_price  = d.price;
    w.result_amount = d.amount;
    w.result_side   = d.side;
    w.last          = lst;
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid_bits    <= '0;
      id_counter    <= '0;
      stamp_counter <= '0;
      ov            <= 1'b0;
      rd_pend       <= 1'b0;
      we            <= 1'b0;
    end else begin
      we <= add_go || edit_go;
      if (ov && out_ch.ready) ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && !ov) begin
            cmd <= in_ch.data;
            case (in_ch.data.operation)
              OP_ADD: begin
                if (!free_any || id_counter == 32'hFFFF_FFFF) begin
                  ow <= blank(ST_FULL, '0);
                end else begin
                  waddr        <= free_slot;
                  wdata.id     <= id_counter + 32'd1;
                  wdata.price  <= in_ch.data.price;
                  wdata.amount <= in_ch.data.amount;
                  wdata.side   <= in_ch.data.side;
                  wdata.stamp  <= stamp_counter;
                  valid_bits[free_slot] <= 1'b1;
                  id_counter    <= id_counter + 32'd1;
                  stamp_counter <= stamp_counter + 32'd1;
                  ow.status        <= ST_OK;
                  ow.result_id     <= id_counter + 32'd1;
                  ow.result_price  <= in_ch.data.price;
                  ow.result_amount <= in_ch.data.amount;
                  ow.result_side   <= in_ch.data.side;
                  ow.last          <= 1'b1;
                end
                ov <= 1'b1;
              end
              OP_EDIT, OP_DEL, OP_GET, OP_BEST: begin
                state     <= S_SCAN;
                scan_idx  <= '0;
                rd_pend   <= 1'b0;
                hit       <= 1'b0;
                shown     <= '0;
                pass_sell <= 1'b1;
                picks     <= '0;
                pend_v    <= 1'b0;
              end
              OP_CLR: begin
                valid_bits    <= '0;
                id_counter    <= '0;
                stamp_counter <= '0;
                ow <= blank(ST_OK, '0);
                ov <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          rd_pend <= !scan_idx[SLOT_W];
          rd_slot <= scan_idx[SLOT_W-1:0];
          if (!scan_idx[SLOT_W]) scan_idx <= scan_idx + 1'b1;
          if (rd_pend && cand && (!hit || better)) begin
            hit      <= 1'b1;
            hit_slot <= rd_slot;
            hit_data <= rdata;
          end
          if (scan_idx[SLOT_W] && !rd_pend) state <= S_DONE;
        end
        S_DONE: begin
          state <= S_WAIT;
          case (cmd.operation)
            OP_BEST: begin
              if (hit) begin
                // the held word is not the final one; hold the new one
                shown[hit_slot] <= 1'b1;
                pend_v          <= 1'b1;
                pend            <= hit_data;
                if (pend_v) begin
                  ow <= slot_word(pend, 1'b0);
                  ov <= 1'b1;
                end
                best_more <= 1'b1;
                if (pass_sell && picks == PICK_W'(BEST_PER_SIDE - 1)) begin
                  pass_sell <= 1'b0;
                  picks     <= '0;
                end else begin
                  picks <= picks + 1'b1;
                end
              end else if (pass_sell) begin
                // no more sells: go straight to the buy pass
                pass_sell <= 1'b0;
                picks     <= '0;
                best_more <= 1'b1;
              end else begin
                // buys exhausted or full: close with the held word, or an empty word if none
                best_more <= 1'b0;
                ow <= pend_v ? slot_word(pend, 1'b1) : blank(ST_EMPTY, '0);
                ov <= 1'b1;
              end
            end
            default: begin
              if (!hit) begin
                ow <= blank(ST_NF, cmd.order_id);
              end else begin
                ow.status        <= ST_OK;
                ow.result_id     <= hit_data.id;
                ow.result_amount <= cmd.operation == OP_EDIT ? cmd.amount : hit_data.amount;
                ow.result_side   <= cmd.operation == OP_EDIT ? cmd.side : hit_data.side;
                ow.result_price  <= cmd.operation == OP_EDIT ? cmd.price : hit_data.price;
                ow.last          <= 1'b1;
                if (cmd.operation == OP_EDIT) begin
                  waddr        <= hit_slot;
                  wdata.id     <= hit_data.id;
                  wdata.price  <= cmd.price;
                  wdata.amount <= cmd.amount;
                  wdata.side   <= cmd.side;
                  // a price change re-queues the order at its new level
                  wdata.stamp  <= (hit_data.price != cmd.price) ? stamp_counter
                                                                : hit_data.stamp;
                  if (hit_data.price != cmd.price) stamp_counter <= stamp_counter + 32'd1;
                end
                if (cmd.operation == OP_DEL) valid_bits[hit_slot] <= 1'b0;
              end
              ov <= 1'b1;
            end
          endcase
        end
        S_WAIT: begin
          // pending word must be taken before next scan/idle
          if (!ov || out_ch.ready) begin
            if (cmd.operation == OP_BEST && best_more) begin
              hit <= 1'b0;
              if (!pass_sell && picks == PICK_W'(BEST_PER_SIDE)) begin
                // buy side full: no sweep, just close
                state <= S_DONE;
              end else begin
                state    <= S_SCAN;
                scan_idx <= '0;
                rd_pend  <= 1'b0;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
